// ===== rtl/lcdscr_pkg.sv =====
// Shared types and constants for the scrolling character display writer.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package lcdscr_pkg;

  // Default number of display columns per line.
  localparam int COLUMNS_DEF = 16;

  // Display controller command bytes.
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_SET_ADDR = 8'h80;
  localparam logic [7:0] LINE2_ADDR   = 8'h40;

  // Source of the next byte placed in the output register.
  typedef enum logic [1:0] {
    SEL_CLEAR,
    SEL_ADDR1,
    SEL_ADDR2,
    SEL_DATA
  } byte_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      accept;  // store the incoming character
    logic      load;    // load one byte into the output register
    logic      k_inc;   // advance the character index
    byte_sel_t sel;     // which byte to load
    logic      last;    // flag the loaded byte as the final one
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;     // output register can take a byte this cycle
    logic k_is_final;   // index points at the newest stored character
    logic k_line1_end;  // index points at the last column of line one
    logic cnt_ge_cols;  // a full first line is stored
    logic cnt_eq_cols;  // exactly one line is stored
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/lcdscr_dp.sv =====
// Datapath: character ring memory, oldest position and fill count, read index,
// and the output register. Depends on lcdscr_pkg.
`default_nettype none

module lcdscr_dp
  import lcdscr_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] char_code,
  input  wire dp_cmd_t    cmd,
  output dp_status_t      status,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      lcd_byte,
  output logic            is_data,
  output logic            last
);

  localparam int DEPTH = 2 * COLUMNS;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] COLS_C   = CNT_W'(COLUMNS);
  localparam logic [IDX_W-1:0] COL_LAST = IDX_W'(COLUMNS - 1);
  localparam logic [IDX_W-1:0] TOP_IDX  = IDX_W'(DEPTH - 1);

  logic [7:0]       ring [DEPTH];
  logic [7:0]       rd_q;
  logic [IDX_W-1:0] oldest;
  logic [IDX_W-1:0] oldest_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] k_next;
  logic [IDX_W:0]   rd_sum;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W:0]   wr_sum;
  logic [IDX_W-1:0] wr_addr;
  logic             full;
  logic [7:0]       byte_mux;

  // Append bookkeeping: drop the oldest entry when the ring is full.
  always_comb begin
    full        = (count == DEPTH_C);
    wr_sum      = {1'b0, oldest} + (IDX_W + 1)'(count);
    oldest_next = oldest;
    count_next  = count;
    if (full) begin
      wr_addr = oldest;
      if (oldest == TOP_IDX) begin
        oldest_next = '0;
      end else begin
        oldest_next = oldest + 1'b1;
      end
    end else begin
      wr_addr    = (wr_sum >= DEPTH_X) ? IDX_W'(wr_sum - DEPTH_X) : wr_sum[IDX_W-1:0];
      count_next = count + 1'b1;
    end
  end

  // Character index: cleared on a new character, stepped per data byte.
  always_comb begin
    k_next = k;
    if (cmd.accept) begin
      k_next = '0;
    end else if (cmd.k_inc) begin
      k_next = k + 1'b1;
    end
  end

  // Read address uses k_next so the registered rd_q matches the current index.
  always_comb begin
    rd_sum  = {1'b0, oldest} + {1'b0, k_next};
    rd_addr = (rd_sum >= DEPTH_X) ? IDX_W'(rd_sum - DEPTH_X) : rd_sum[IDX_W-1:0];
  end

  // Ring memory with a registered read port.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ring[wr_addr] <= char_code;
    end
    rd_q <= ring[rd_addr];
  end

  // Pointer, count and index registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest <= '0;
      count  <= '0;
      k      <= '0;
    end else begin
      k <= k_next;
      if (cmd.accept) begin
        oldest <= oldest_next;
        count  <= count_next;
      end
    end
  end

  // Byte selection for the output register.
  always_comb begin
    case (cmd.sel)
      SEL_CLEAR: byte_mux = CMD_CLEAR;
      SEL_ADDR1: byte_mux = CMD_SET_ADDR;
      SEL_ADDR2: byte_mux = CMD_SET_ADDR | LINE2_ADDR;
      SEL_DATA:  byte_mux = rd_q;
      default:   byte_mux = CMD_CLEAR;
    endcase
  end

  // Output register; it holds while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.load) begin
      lcd_byte <= byte_mux;
      is_data  <= (cmd.sel == SEL_DATA);
      last     <= cmd.last;
    end
  end

  // Status for the controller.
  always_comb begin
    status.out_free    = !out_valid || !out_stall;
    status.k_is_final  = (CNT_W'(k) == count - 1'b1);
    status.k_line1_end = (k == COL_LAST);
    status.cnt_ge_cols = (count >= COLS_C);
    status.cnt_eq_cols = (count == COLS_C);
  end

endmodule

`default_nettype wire

// ===== rtl/lcdscr_ctrl.sv =====
// Controller: sequences one redraw run per stored character.
// Depends on lcdscr_pkg; drives the datapath through dp_cmd_t.
`default_nettype none

module lcdscr_ctrl
  import lcdscr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_ADDR1,
    ST_LINE1,
    ST_ADDR2,
    ST_LINE2
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd.accept = 1'b0;
    cmd.load   = 1'b0;
    cmd.k_inc  = 1'b0;
    cmd.sel    = SEL_CLEAR;
    cmd.last   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        cmd.sel = SEL_CLEAR;
        if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_ADDR1;
        end
      end
      ST_ADDR1: begin
        cmd.sel = SEL_ADDR1;
        if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_LINE1;
        end
      end
      ST_LINE1: begin
        cmd.sel  = SEL_DATA;
        cmd.last = status.k_is_final && !status.cnt_ge_cols;
        if (status.out_free) begin
          cmd.load  = 1'b1;
          cmd.k_inc = 1'b1;
          if (cmd.last) begin
            state_next = ST_IDLE;
          end else if (status.k_line1_end) begin
            state_next = ST_ADDR2;
          end
        end
      end
      ST_ADDR2: begin
        cmd.sel  = SEL_ADDR2;
        cmd.last = status.cnt_eq_cols;
        if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = cmd.last ? ST_IDLE : ST_LINE2;
        end
      end
      ST_LINE2: begin
        cmd.sel  = SEL_DATA;
        cmd.last = status.k_is_final;
        if (status.out_free) begin
          cmd.load  = 1'b1;
          cmd.k_inc = 1'b1;
          if (cmd.last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lcd_scrolling_text_writer_unit.sv =====
// Top level of the scrolling text writer for a two-line character display.
// Depends on lcdscr_pkg, lcdscr_ctrl and lcdscr_dp.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  char_code[7:0]
//   output   out        out_valid/out_stall  lcd_byte[7:0], is_data, last
//
// Each character is stored and the display is then redrawn with at most
// 3 + 2*COLUMNS bytes, so 35 bytes per request at COLUMNS = 16. Unless the
// output stalls, the controller emits one byte per cycle into the single output register.
// Reset clears the fill count and oldest position; ring contents need no reset.
// A stall on the output holds the controller in place; in_stall stays high
// until the final byte of the run has been loaded into the output register.
`default_nettype none

module lcd_scrolling_text_writer_unit
  import lcdscr_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] char_code,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      lcd_byte,
  output logic            is_data,
  output logic            last
);

  dp_cmd_t    cmd;
  dp_status_t status;

  lcdscr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lcdscr_dp #(
    .COLUMNS (COLUMNS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .char_code (char_code),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .lcd_byte  (lcd_byte),
    .is_data   (is_data),
    .last      (last)
  );

endmodule

`default_nettype wire
